FILE: hdl/cfs_pkg.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Motion cross-fade selector package
// Shared types, codes and reset constants of the cross-fade selector.
//------------------------------------------------------------------------------
package cfs_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned FADE_W   = 16;
    localparam int unsigned CODE_W   = 6;
    localparam int unsigned RATIO_W  = 17;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [RATIO_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic [FADE_W-1:0] FADE_TO_SPECIAL_RST = 16'd200;
    localparam logic [FADE_W-1:0] FADE_TO_WALK_RST    = 16'd300;
    localparam logic [FADE_W-1:0] PLAY_DEAD_DELAY_RST = 16'd2000;
    localparam logic [CODE_W-1:0] STAND_UP_BACK_RST   = 6'd1;
    localparam logic [CODE_W-1:0] STAND_UP_FRONT_RST  = 6'd2;
    localparam logic [CODE_W-1:0] PLAY_DEAD_RST       = 6'd0;
    localparam logic [CODE_W-1:0] NO_ACTION_RST       = 6'd63;

    localparam logic MOTION_SPECIAL = 1'b0;
    localparam logic MOTION_WALK    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FADE_TO_SPECIAL = 3'd0,
        REG_FADE_TO_WALK    = 3'd1,
        REG_PLAY_DEAD_DELAY = 3'd2,
        REG_STAND_UP_BACK   = 3'd3,
        REG_STAND_UP_FRONT  = 3'd4,
        REG_PLAY_DEAD       = 3'd5,
        REG_NO_ACTION       = 3'd6
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_FORWARD   = 2'd0,
        KIND_DEFAULT   = 2'd1,
        KIND_NO_ACTION = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_DEACTIVE = 2'd0,
        MODE_FIRST    = 2'd1,
        MODE_ACTIVE   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

FILE: hdl/cfs_if.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Motion cross-fade selector channels
// Frame input, result output and configuration write channels.
//------------------------------------------------------------------------------
`default_nettype none

interface cfs_frame_if;
    logic                             valid;
    logic                             ready;
    logic [cfs_pkg::TIME_W-1:0]       now_ms;
    logic                             requested_motion;
    logic [cfs_pkg::CODE_W-1:0]       requested_action;
    logic                             special_can_leave;
    logic                             walk_can_leave;

    modport source (output valid, now_ms, requested_motion, requested_action,
                    special_can_leave, walk_can_leave, input ready);
    modport sink   (input valid, now_ms, requested_motion, requested_action,
                    special_can_leave, walk_can_leave, output ready);
endinterface

interface cfs_result_if;
    logic                             valid;
    logic                             ready;
    logic                             target_motion;
    logic                             forward_walk_request;
    logic [1:0]                       action_request_kind;
    logic [cfs_pkg::RATIO_W-1:0]      special_ratio;
    logic [cfs_pkg::RATIO_W-1:0]      walk_ratio;
    logic [1:0]                       special_mode;

    modport source (output valid, target_motion, forward_walk_request,
                    action_request_kind, special_ratio, walk_ratio, special_mode,
                    input ready);
    modport sink   (input valid, target_motion, forward_walk_request,
                    action_request_kind, special_ratio, walk_ratio, special_mode,
                    output ready);
endinterface

interface cfs_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [cfs_pkg::CFG_IDX_W-1:0]    index;
    logic [cfs_pkg::FADE_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/motion_crossfade_selector.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Motion cross-fade selector
// Picks the target motion per control frame, decides forwarded requests and
// cross-fades the special-action and walk blend ratios in Q1.16.
//------------------------------------------------------------------------------
// Flow: frame transfer, calculation, then the 16-step serial divider when the fade
// step needs a division, then the finish state that loads the result. One frame
// at a time; the next frame is taken in the cycle after the result is loaded.
// Reset: control, configuration and persistent state and the output valid return
// to their reset values at once, with no clearing pass; the frame, work and result
// data registers are not reset.
//------------------------------------------------------------------------------
`default_nettype none

module motion_crossfade_selector (
    input  wire logic          clk,
    input  wire logic          rst_n,
    cfs_frame_if.sink          frame,
    cfs_result_if.source       result,
    cfs_cfg_if.sink            cfg
);

    localparam int unsigned TW = cfs_pkg::TIME_W;
    localparam int unsigned FW = cfs_pkg::FADE_W;
    localparam int unsigned CW = cfs_pkg::CODE_W;
    localparam int unsigned RW = cfs_pkg::RATIO_W;

    // Configuration registers.
    logic [FW-1:0] fade_special_reg;
    logic [FW-1:0] fade_walk_reg;
    logic [FW-1:0] play_dead_delay_reg;
    logic [CW-1:0] stand_back_reg;
    logic [CW-1:0] stand_front_reg;
    logic [CW-1:0] play_dead_reg;
    logic [CW-1:0] no_action_reg;

    // Persistent state.
    logic [TW-1:0] last_time_reg;
    logic          last_motion_reg;
    logic          prev_motion_reg;
    logic          target_reg;
    logic          target_next;
    logic [RW-1:0] blend_reg;
    logic [RW-1:0] blend_next;
    logic [CW-1:0] last_action_reg;
    logic [CW-1:0] last_action_next;

    // Captured frame and per-frame work registers.
    logic [TW-1:0]  now_reg;
    logic           req_reg;
    logic [CW-1:0]  action_reg;
    logic           sp_leave_reg;
    logic           wk_leave_reg;
    logic           skip_reg;
    logic           fwd_reg;
    logic           fwd_next;
    cfs_pkg::kind_t kind_reg;
    cfs_pkg::kind_t kind_next;
    logic [RW-1:0]  step_reg;

    // Result registers.
    logic           out_valid_reg;
    logic           out_target_reg;
    logic           out_fwd_reg;
    cfs_pkg::kind_t out_kind_reg;
    logic [RW-1:0]  out_special_reg;
    logic [RW-1:0]  out_walk_reg;
    cfs_pkg::mode_t out_mode_reg;
    cfs_pkg::mode_t mode_next;

    cfs_pkg::state_t state_reg;
    cfs_pkg::state_t state_next;

    logic            frame_fire;
    logic            cfg_fire;
    logic            skip;
    logic            standup;
    logic            take_req;
    logic [TW-1:0]   dt;
    logic [FW-1:0]   fade_time;
    logic            saturate;
    logic            div_start;
    logic            load_out;
    logic [RW:0]     blend_sum;
    cfs_pkg::div_status_t div_status;
    logic [FW-1:0]   div_quotient;

    assign frame_fire = frame.valid && frame.ready;
    assign cfg_fire   = cfg.valid && cfg.ready;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_special_reg    <= cfs_pkg::FADE_TO_SPECIAL_RST;
            fade_walk_reg       <= cfs_pkg::FADE_TO_WALK_RST;
            play_dead_delay_reg <= cfs_pkg::PLAY_DEAD_DELAY_RST;
            stand_back_reg      <= cfs_pkg::STAND_UP_BACK_RST;
            stand_front_reg     <= cfs_pkg::STAND_UP_FRONT_RST;
            play_dead_reg       <= cfs_pkg::PLAY_DEAD_RST;
            no_action_reg       <= cfs_pkg::NO_ACTION_RST;
        end
        else if (cfg_fire)
        begin
            case (cfg.index)
                cfs_pkg::REG_FADE_TO_SPECIAL: fade_special_reg    <= cfg.data;
                cfs_pkg::REG_FADE_TO_WALK:    fade_walk_reg       <= cfg.data;
                cfs_pkg::REG_PLAY_DEAD_DELAY: play_dead_delay_reg <= cfg.data;
                cfs_pkg::REG_STAND_UP_BACK:   stand_back_reg      <= cfg.data[CW-1:0];
                cfs_pkg::REG_STAND_UP_FRONT:  stand_front_reg     <= cfg.data[CW-1:0];
                cfs_pkg::REG_PLAY_DEAD:       play_dead_reg       <= cfg.data[CW-1:0];
                cfs_pkg::REG_NO_ACTION:       no_action_reg       <= cfg.data[CW-1:0];
                default:                      ;
            endcase
        end
    end

    // Target selection, request forwarding and fade time.
    always_comb
    begin
        skip    = (last_time_reg == '0);
        standup = (req_reg == cfs_pkg::MOTION_SPECIAL) &&
                  ((action_reg == stand_back_reg) || (action_reg == stand_front_reg));
        take_req = ((last_motion_reg == cfs_pkg::MOTION_SPECIAL) && sp_leave_reg) ||
                   standup ||
                   ((last_motion_reg == cfs_pkg::MOTION_WALK) && wk_leave_reg);
        target_next = (!skip && take_req) ? req_reg : target_reg;
        fwd_next = !skip && (req_reg == cfs_pkg::MOTION_WALK) &&
                   (last_motion_reg == cfs_pkg::MOTION_WALK);
        if (skip)
        begin
            kind_next = cfs_pkg::KIND_DEFAULT;
        end
        else if (req_reg == cfs_pkg::MOTION_SPECIAL)
        begin
            kind_next = cfs_pkg::KIND_FORWARD;
        end
        else if (target_next == cfs_pkg::MOTION_SPECIAL)
        begin
            kind_next = cfs_pkg::KIND_NO_ACTION;
        end
        else
        begin
            kind_next = cfs_pkg::KIND_DEFAULT;
        end
        dt = now_reg - last_time_reg;
        if ((prev_motion_reg == cfs_pkg::MOTION_SPECIAL) && (last_action_reg == play_dead_reg))
        begin
            fade_time = play_dead_delay_reg;
        end
        else if (target_next == cfs_pkg::MOTION_SPECIAL)
        begin
            fade_time = fade_special_reg;
        end
        else
        begin
            fade_time = fade_walk_reg;
        end
        // An elapsed time at or above the fade time, or a zero fade time, gives a full step of 1.0.
        saturate = (fade_time == '0) || (dt >= {{(TW-FW){1'b0}}, fade_time});
    end

    // Blend update, mode and remembered action.
    always_comb
    begin
        blend_sum = {1'b0, blend_reg} + {1'b0, step_reg};
        if (skip_reg)
        begin
            blend_next = blend_reg;
        end
        else if (target_reg == cfs_pkg::MOTION_SPECIAL)
        begin
            blend_next = (blend_sum < {1'b0, cfs_pkg::ONE_Q16}) ? blend_sum[RW-1:0]
                                                               : cfs_pkg::ONE_Q16;
        end
        else
        begin
            blend_next = (blend_reg > step_reg) ? (blend_reg - step_reg) : '0;
        end
        if (blend_next < cfs_pkg::ONE_Q16)
        begin
            mode_next = (target_reg == cfs_pkg::MOTION_SPECIAL) ? cfs_pkg::MODE_FIRST
                                                                : cfs_pkg::MODE_DEACTIVE;
        end
        else
        begin
            mode_next = cfs_pkg::MODE_ACTIVE;
        end
        last_action_next = last_action_reg;
        if (!skip_reg && (mode_next == cfs_pkg::MODE_ACTIVE))
        begin
            if ((kind_reg == cfs_pkg::KIND_FORWARD) && (action_reg != no_action_reg))
            begin
                last_action_next = action_reg;
            end
            else if (kind_reg == cfs_pkg::KIND_DEFAULT)
            begin
                last_action_next = play_dead_reg;
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cfs_pkg::ST_IDLE:
            begin
                if (frame_fire)
                begin
                    state_next = cfs_pkg::ST_CALC;
                end
            end
            cfs_pkg::ST_CALC:
            begin
                state_next = (skip || saturate) ? cfs_pkg::ST_FINISH : cfs_pkg::ST_DIV;
            end
            cfs_pkg::ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = cfs_pkg::ST_FINISH;
                end
            end
            cfs_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = cfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cfs_pkg::ST_IDLE;
            end
        endcase
    end

    // State machine outputs.
    always_comb
    begin
        frame.ready = (state_reg == cfs_pkg::ST_IDLE);
        div_start   = (state_reg == cfs_pkg::ST_CALC) && !skip && !saturate;
        load_out    = (state_reg == cfs_pkg::ST_FINISH) && (!out_valid_reg || result.ready);
    end

    cfs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dt[FW-1:0]),
        .divisor  (fade_time),
        .status   (div_status),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= cfs_pkg::ST_IDLE;
            last_time_reg   <= '0;
            last_motion_reg <= cfs_pkg::MOTION_SPECIAL;
            prev_motion_reg <= cfs_pkg::MOTION_SPECIAL;
            target_reg      <= cfs_pkg::MOTION_SPECIAL;
            blend_reg       <= cfs_pkg::ONE_Q16;
            last_action_reg <= cfs_pkg::PLAY_DEAD_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == cfs_pkg::ST_CALC)
            begin
                target_reg <= target_next;
            end
            if (load_out)
            begin
                last_time_reg   <= now_reg;
                last_motion_reg <= target_reg;
                if (last_motion_reg != target_reg)
                begin
                    prev_motion_reg <= last_motion_reg;
                end
                blend_reg       <= blend_next;
                last_action_reg <= last_action_next;
                out_valid_reg   <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_fire)
        begin
            now_reg      <= frame.now_ms;
            req_reg      <= frame.requested_motion;
            action_reg   <= frame.requested_action;
            sp_leave_reg <= frame.special_can_leave;
            wk_leave_reg <= frame.walk_can_leave;
        end
        if (state_reg == cfs_pkg::ST_CALC)
        begin
            skip_reg <= skip;
            fwd_reg  <= fwd_next;
            kind_reg <= kind_next;
            step_reg <= cfs_pkg::ONE_Q16;
        end
        else if ((state_reg == cfs_pkg::ST_DIV) && div_status.done)
        begin
            step_reg <= {{(RW-FW){1'b0}}, div_quotient};
        end
        if (load_out)
        begin
            out_target_reg  <= target_reg;
            out_fwd_reg     <= fwd_reg;
            out_kind_reg    <= kind_reg;
            out_special_reg <= blend_next;
            out_walk_reg    <= cfs_pkg::ONE_Q16 - blend_next;
            out_mode_reg    <= mode_next;
        end
    end

    assign result.valid                = out_valid_reg;
    assign result.target_motion        = out_target_reg;
    assign result.forward_walk_request = out_fwd_reg;
    assign result.action_request_kind  = out_kind_reg;
    assign result.special_ratio        = out_special_reg;
    assign result.walk_ratio           = out_walk_reg;
    assign result.special_mode         = out_mode_reg;

`ifndef SYNTHESIS
    a_frame_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
        frame_fire |=> (state_reg == cfs_pkg::ST_CALC))
        else $error("Frame transfer did not start the calculation.");

    a_div_done_finish: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == cfs_pkg::ST_DIV) && div_status.done) |=>
            (state_reg == cfs_pkg::ST_FINISH))
        else $error("Divider completion did not lead to the finish state.");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("Result load did not raise the output valid.");

    a_active_full_ratio: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_mode_reg == cfs_pkg::MODE_ACTIVE)) |->
            (out_special_reg == cfs_pkg::ONE_Q16))
        else $error("Active mode reported with a special ratio below 1.0.");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cfs_pkg::ST_FINISH) |-> (step_reg <= cfs_pkg::ONE_Q16))
        else $error("Fade step exceeds 1.0.");
`endif

endmodule

`default_nettype wire

FILE: hdl/cfs_div.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Cross-fade step divider
// Bit-serial restoring divider for (dividend * 2^16) / divisor, valid when the
// dividend is below the divisor; one quotient bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none

module cfs_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [cfs_pkg::FADE_W-1:0]    dividend,
    input  wire logic [cfs_pkg::FADE_W-1:0]    divisor,
    output      cfs_pkg::div_status_t          status,
    output      logic [cfs_pkg::FADE_W-1:0]    quotient
);

    localparam int unsigned W     = cfs_pkg::FADE_W;
    localparam int unsigned CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W - 1);

    logic [W-1:0]     rem_reg;
    logic [W-1:0]     rem_next;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [W:0]       trial;
    logic             q_bit;

    always_comb
    begin
        trial = {rem_reg, 1'b0} - {1'b0, dsr_reg};
        q_bit = ~trial[W] | rem_reg[W-1];
        if (q_bit)
        begin
            rem_next = trial[W-1:0];
        end
        else
        begin
            rem_next = {rem_reg[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dsr_reg <= divisor;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[W-2:0], q_bit};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

`default_nettype wire

FILE: test/motion_crossfade_checker.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Motion cross-fade selector checker
// Watches the frame, result and register write channels of the selector. It
// keeps its own copy of the selection and blend state, works out the expected
// result for every frame transfer and compares each result transfer with the
// oldest outstanding prediction, field by field.
//------------------------------------------------------------------------------
module motion_crossfade_checker (
    input  logic    clk,
    input  logic    rst_n,
    cfs_frame_if    frame,
    cfs_result_if   result,
    cfs_cfg_if      cfg,
    output int      fail_count,
    output int      checked_count,
    output int      expected_left
);

    typedef struct packed {
        logic                        target;
        logic                        fwd_walk;
        cfs_pkg::kind_t              kind;
        logic [cfs_pkg::RATIO_W-1:0] special_ratio;
        logic [cfs_pkg::RATIO_W-1:0] walk_ratio;
        cfs_pkg::mode_t              mode;
    } selection_t;

    logic [cfs_pkg::FADE_W-1:0]  fade_special;
    logic [cfs_pkg::FADE_W-1:0]  fade_walk;
    logic [cfs_pkg::FADE_W-1:0]  dead_delay;
    logic [cfs_pkg::CODE_W-1:0]  code_back;
    logic [cfs_pkg::CODE_W-1:0]  code_front;
    logic [cfs_pkg::CODE_W-1:0]  code_dead;
    logic [cfs_pkg::CODE_W-1:0]  code_none;

    logic [cfs_pkg::TIME_W-1:0]  stamp_prev;
    logic                        motion_last;
    logic                        motion_prev;
    logic                        target_now;
    logic [cfs_pkg::RATIO_W-1:0] special_blend;
    logic [cfs_pkg::CODE_W-1:0]  action_memo;

    selection_t selections_due[$];

    function automatic cfs_pkg::mode_t mode_from(logic [cfs_pkg::RATIO_W-1:0] blend,
                                                 logic target);
        if (blend < cfs_pkg::ONE_Q16)
        begin
            return (target == cfs_pkg::MOTION_SPECIAL) ? cfs_pkg::MODE_FIRST
                                                       : cfs_pkg::MODE_DEACTIVE;
        end
        return cfs_pkg::MODE_ACTIVE;
    endfunction

    function automatic selection_t predict_selection(
        logic [cfs_pkg::TIME_W-1:0] now,
        logic                       req,
        logic [cfs_pkg::CODE_W-1:0] action,
        logic                       sp_leave,
        logic                       wk_leave
    );
        selection_t                  sel;
        logic                        standup;
        logic [cfs_pkg::TIME_W-1:0]  dt;
        logic [cfs_pkg::FADE_W-1:0]  fade_ms;
        logic [63:0]                 quot;
        logic [cfs_pkg::RATIO_W-1:0] step;
        logic [cfs_pkg::RATIO_W-1:0] other;
        sel.fwd_walk = 1'b0;
        sel.kind = cfs_pkg::KIND_DEFAULT;
        if (stamp_prev != '0)
        begin
            standup = (req == cfs_pkg::MOTION_SPECIAL) &&
                      (action == code_back || action == code_front);
            if ((motion_last == cfs_pkg::MOTION_SPECIAL && sp_leave) || standup ||
                (motion_last == cfs_pkg::MOTION_WALK && wk_leave))
            begin
                target_now = req;
            end
            sel.fwd_walk = (req == cfs_pkg::MOTION_WALK) &&
                           (motion_last == cfs_pkg::MOTION_WALK);
            if (req == cfs_pkg::MOTION_SPECIAL)
            begin
                sel.kind = cfs_pkg::KIND_FORWARD;
            end
            else
            begin
                sel.kind = (target_now == cfs_pkg::MOTION_SPECIAL) ? cfs_pkg::KIND_NO_ACTION
                                                                   : cfs_pkg::KIND_DEFAULT;
            end
            dt = now - stamp_prev;
            if (motion_prev == cfs_pkg::MOTION_SPECIAL && action_memo == code_dead)
            begin
                fade_ms = dead_delay;
            end
            else
            begin
                fade_ms = (target_now == cfs_pkg::MOTION_SPECIAL) ? fade_special : fade_walk;
            end
            if (fade_ms == '0)
            begin
                step = cfs_pkg::ONE_Q16;
            end
            else
            begin
                quot = {16'd0, dt, 16'd0} / {48'd0, fade_ms};
                step = (quot > 64'(cfs_pkg::ONE_Q16)) ? cfs_pkg::ONE_Q16
                                                      : quot[cfs_pkg::RATIO_W-1:0];
            end
            if (target_now == cfs_pkg::MOTION_SPECIAL)
            begin
                other = cfs_pkg::ONE_Q16 - special_blend;
                other = (other > step) ? other - step : '0;
                special_blend = cfs_pkg::ONE_Q16 - other;
            end
            else
            begin
                special_blend = (special_blend > step) ? special_blend - step : '0;
            end
            sel.mode = mode_from(special_blend, target_now);
            if (sel.mode == cfs_pkg::MODE_ACTIVE)
            begin
                if (sel.kind == cfs_pkg::KIND_FORWARD && action != code_none)
                begin
                    action_memo = action;
                end
                else if (sel.kind == cfs_pkg::KIND_DEFAULT)
                begin
                    action_memo = code_dead;
                end
            end
        end
        else
        begin
            sel.mode = mode_from(special_blend, target_now);
        end
        stamp_prev = now;
        if (motion_last != target_now)
        begin
            motion_prev = motion_last;
        end
        motion_last = target_now;
        sel.target = target_now;
        sel.special_ratio = special_blend;
        sel.walk_ratio = cfs_pkg::ONE_Q16 - special_blend;
        return sel;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        selection_t due;
        if (!rst_n)
        begin
            fade_special  = cfs_pkg::FADE_TO_SPECIAL_RST;
            fade_walk     = cfs_pkg::FADE_TO_WALK_RST;
            dead_delay    = cfs_pkg::PLAY_DEAD_DELAY_RST;
            code_back     = cfs_pkg::STAND_UP_BACK_RST;
            code_front    = cfs_pkg::STAND_UP_FRONT_RST;
            code_dead     = cfs_pkg::PLAY_DEAD_RST;
            code_none     = cfs_pkg::NO_ACTION_RST;
            stamp_prev    = '0;
            motion_last   = cfs_pkg::MOTION_SPECIAL;
            motion_prev   = cfs_pkg::MOTION_SPECIAL;
            target_now    = cfs_pkg::MOTION_SPECIAL;
            special_blend = cfs_pkg::ONE_Q16;
            action_memo   = cfs_pkg::PLAY_DEAD_RST;
            selections_due.delete();
            fail_count    = 0;
            checked_count = 0;
            expected_left <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfs_pkg::cfg_reg_t'(cfg.index))
                    cfs_pkg::REG_FADE_TO_SPECIAL: fade_special = cfg.data;
                    cfs_pkg::REG_FADE_TO_WALK:    fade_walk    = cfg.data;
                    cfs_pkg::REG_PLAY_DEAD_DELAY: dead_delay   = cfg.data;
                    cfs_pkg::REG_STAND_UP_BACK:   code_back    = cfg.data[cfs_pkg::CODE_W-1:0];
                    cfs_pkg::REG_STAND_UP_FRONT:  code_front   = cfg.data[cfs_pkg::CODE_W-1:0];
                    cfs_pkg::REG_PLAY_DEAD:       code_dead    = cfg.data[cfs_pkg::CODE_W-1:0];
                    cfs_pkg::REG_NO_ACTION:       code_none    = cfg.data[cfs_pkg::CODE_W-1:0];
                    default: ;
                endcase
            end
            if (frame.valid && frame.ready)
            begin
                selections_due.push_back(predict_selection(frame.now_ms, frame.requested_motion,
                    frame.requested_action, frame.special_can_leave, frame.walk_can_leave));
            end
            if (result.valid && result.ready)
            begin
                if (selections_due.size() == 0)
                begin
                    $error("Result transfer arrived with no frame outstanding.");
                    fail_count++;
                end
                else
                begin
                    due = selections_due.pop_front();
                    checked_count++;
                    compare_field("target_motion", 32'(due.target), 32'(result.target_motion));
                    compare_field("forward_walk_request", 32'(due.fwd_walk),
                                  32'(result.forward_walk_request));
                    compare_field("action_request_kind", 32'(due.kind),
                                  32'(result.action_request_kind));
                    compare_field("special_ratio", 32'(due.special_ratio),
                                  32'(result.special_ratio));
                    compare_field("walk_ratio", 32'(due.walk_ratio), 32'(result.walk_ratio));
                    compare_field("special_mode", 32'(due.mode), 32'(result.special_mode));
                end
            end
            expected_left <= selections_due.size();
        end
    end

endmodule

FILE: test/motion_crossfade_selector_tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// Motion cross-fade selector testbench
// Drives control frames and register writes into the selector and takes its
// results with random gaps on both sides. A directed sequence walks through
// skipped frames, motion switches, stand-up overrides, play-dead delays and
// timestamp wrap; random frames then follow under several register settings,
// including the extremes and a long output stall. The checker beside the block
// predicts and compares every result.
//------------------------------------------------------------------------------
module motion_crossfade_selector_tb;

    typedef logic [cfs_pkg::CODE_W-1:0] code_t;

    logic                        clk;
    logic                        rst_n;
    int                          fail_count;
    int                          checked_count;
    int                          expected_left;
    int                          pace = 2;
    int                          hold_request = 0;
    int                          frames_sent = 0;
    int                          settings_loaded = 0;
    logic [cfs_pkg::TIME_W-1:0]  stamp_ms = '0;
    logic                        want_walk = cfs_pkg::MOTION_WALK;
    code_t                       stim_back  = cfs_pkg::STAND_UP_BACK_RST;
    code_t                       stim_front = cfs_pkg::STAND_UP_FRONT_RST;
    code_t                       stim_dead  = cfs_pkg::PLAY_DEAD_RST;
    code_t                       stim_none  = cfs_pkg::NO_ACTION_RST;

    cfs_frame_if  frame_ch ();
    cfs_result_if result_ch ();
    cfs_cfg_if    cfg_ch ();

    motion_crossfade_selector u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    motion_crossfade_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame         (frame_ch),
        .result        (result_ch),
        .cfg           (cfg_ch),
        .fail_count    (fail_count),
        .checked_count (checked_count),
        .expected_left (expected_left)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int draw_gap();
        case (pace)
            0: return 0;
            1: return $urandom_range(0, 11);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
        endcase
    endfunction

    function automatic code_t pick_action();
        case ($urandom_range(0, 5))
            0: return stim_back;
            1: return stim_front;
            2: return stim_dead;
            3: return stim_none;
            default: return code_t'($urandom_range(0, 63));
        endcase
    endfunction

    initial
    begin : result_sink
        int gap;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                gap = hold_request;
                hold_request = 0;
            end
            else
            begin
                gap = draw_gap();
            end
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid) @(posedge clk);
        end
    end

    task automatic send_frame(input logic [cfs_pkg::TIME_W-1:0] now, input logic motion,
                              input code_t action, input logic sp_leave,
                              input logic wk_leave);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_ch.now_ms            <= now;
        frame_ch.requested_motion  <= motion;
        frame_ch.requested_action  <= action;
        frame_ch.special_can_leave <= sp_leave;
        frame_ch.walk_can_leave    <= wk_leave;
        frame_ch.valid             <= 1'b1;
        @(posedge clk);
        while (!frame_ch.ready) @(posedge clk);
        stamp_ms = now;
        frames_sent++;
    endtask

    task automatic send_random_frame();
        int                         pick;
        logic [cfs_pkg::TIME_W-1:0] now;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            now = '0;
        else if (pick < 6)
            now = $urandom();
        else if (pick < 12)
            now = stamp_ms + $urandom_range(0, 70000);
        else if (pick < 30)
            now = stamp_ms + $urandom_range(0, 2500);
        else
            now = stamp_ms + $urandom_range(0, 40);
        if ($urandom_range(0, 4) == 0)
            want_walk = ~want_walk;
        send_frame(now, want_walk, pick_action(), $urandom_range(0, 9) < 6,
                   $urandom_range(0, 9) < 6);
    endtask

    task automatic wait_results_drained();
        frame_ch.valid <= 1'b0;
        do @(posedge clk); while (expected_left != 0);
    endtask

    task automatic write_reg(input cfs_pkg::cfg_reg_t idx,
                             input logic [cfs_pkg::FADE_W-1:0] value);
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
    endtask

    // Code registers get random upper data bits, which the block must drop.
    task automatic load_settings(input logic [cfs_pkg::FADE_W-1:0] to_special, to_walk,
                                 dead_ms, input code_t back, front, dead, none);
        write_reg(cfs_pkg::REG_FADE_TO_SPECIAL, to_special);
        write_reg(cfs_pkg::REG_FADE_TO_WALK, to_walk);
        write_reg(cfs_pkg::REG_PLAY_DEAD_DELAY, dead_ms);
        write_reg(cfs_pkg::REG_STAND_UP_BACK, {10'($urandom), back});
        write_reg(cfs_pkg::REG_STAND_UP_FRONT, {10'($urandom), front});
        write_reg(cfs_pkg::REG_PLAY_DEAD, {10'($urandom), dead});
        write_reg(cfs_pkg::REG_NO_ACTION, {10'($urandom), none});
        cfg_ch.valid <= 1'b0;
        stim_back  = back;
        stim_front = front;
        stim_dead  = dead;
        stim_none  = none;
        settings_loaded++;
    endtask

    task automatic run_phase(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 35 == 0)
                pace = $urandom_range(0, 2);
            send_random_frame();
        end
        wait_results_drained();
    endtask

    initial
    begin
        rst_n                      <= 1'b0;
        frame_ch.valid             <= 1'b0;
        frame_ch.now_ms            <= '0;
        frame_ch.requested_motion  <= cfs_pkg::MOTION_SPECIAL;
        frame_ch.requested_action  <= '0;
        frame_ch.special_can_leave <= 1'b0;
        frame_ch.walk_can_leave    <= 1'b0;
        cfg_ch.valid               <= 1'b0;
        cfg_ch.index               <= cfs_pkg::REG_FADE_TO_SPECIAL;
        cfg_ch.data                <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // The first frame after reset finds a zero last time and is skipped.
        send_frame(32'd1000, cfs_pkg::MOTION_WALK, 6'd5, 1'b1, 1'b1);
        send_frame(32'd1010, cfs_pkg::MOTION_WALK, 6'd5, 1'b0, 1'b0);
        send_frame(32'd1020, cfs_pkg::MOTION_WALK, 6'd5, 1'b1, 1'b0);
        send_frame(32'd1520, cfs_pkg::MOTION_WALK, 6'd40, 1'b0, 1'b0);
        send_frame(32'd3520, cfs_pkg::MOTION_WALK, 6'd0, 1'b0, 1'b0);
        send_frame(32'd3530, cfs_pkg::MOTION_SPECIAL, stim_back, 1'b0, 1'b0);
        send_frame(32'h0001_0000, cfs_pkg::MOTION_SPECIAL, stim_front, 1'b0, 1'b1);
        send_frame(32'h0001_000A, cfs_pkg::MOTION_SPECIAL, stim_none, 1'b1, 1'b0);
        send_frame(32'h0001_0014, cfs_pkg::MOTION_WALK, 6'd21, 1'b0, 1'b1);
        send_frame(32'h0001_001E, cfs_pkg::MOTION_WALK, 6'd42, 1'b1, 1'b0);
        send_frame(32'hFFFF_FFF0, cfs_pkg::MOTION_WALK, 6'd63, 1'b0, 1'b0);
        send_frame(32'h0000_0010, cfs_pkg::MOTION_WALK, 6'd0, 1'b1, 1'b1);
        send_frame(32'h0000_0000, cfs_pkg::MOTION_SPECIAL, 6'd13, 1'b0, 1'b1);
        send_frame(32'd50, cfs_pkg::MOTION_WALK, 6'd13, 1'b1, 1'b1);
        send_frame(32'd60, cfs_pkg::MOTION_SPECIAL, stim_dead, 1'b1, 1'b1);
        send_frame(32'hFFFF_FFFF, cfs_pkg::MOTION_SPECIAL, stim_dead, 1'b0, 1'b0);
        send_frame(32'hFFFF_FFFF, cfs_pkg::MOTION_WALK, 6'd33, 1'b1, 1'b1);
        send_frame(32'h0000_0100, cfs_pkg::MOTION_WALK, 6'd33, 1'b0, 1'b1);
        send_frame(32'h0000_0200, cfs_pkg::MOTION_SPECIAL, stim_front, 1'b0, 1'b0);
        send_frame(32'h0000_0210, cfs_pkg::MOTION_SPECIAL, 6'd62, 1'b1, 1'b1);
        send_frame(32'h7FFF_FFFF, cfs_pkg::MOTION_SPECIAL, 6'd62, 1'b1, 1'b1);
        wait_results_drained();

        run_phase(140);
        load_settings(16'd65535, 16'd65535, 16'd65535, 6'd62, 6'd61, 6'd63, 6'd0);
        run_phase(140);
        load_settings(16'd1, 16'd1, 16'd1, 6'd0, 6'd63, 6'd0, 6'd63);
        run_phase(140);
        load_settings(16'($urandom_range(1, 3000)), 16'($urandom_range(1, 3000)),
                      16'($urandom_range(1, 5000)), 6'($urandom), 6'($urandom),
                      6'($urandom), 6'($urandom));
        run_phase(140);
        load_settings(16'd17, 16'd4000, 16'd9, 6'd5, 6'd5, 6'd9, 6'd5);
        run_phase(140);
        load_settings(cfs_pkg::FADE_TO_SPECIAL_RST, cfs_pkg::FADE_TO_WALK_RST,
                      cfs_pkg::PLAY_DEAD_DELAY_RST, cfs_pkg::STAND_UP_BACK_RST,
                      cfs_pkg::STAND_UP_FRONT_RST, cfs_pkg::PLAY_DEAD_RST,
                      cfs_pkg::NO_ACTION_RST);
        run_phase(140);

        // Hold the result side off while frames keep coming, so the input stalls.
        pace = 0;
        hold_request = 200;
        repeat (30) send_random_frame();
        wait_results_drained();

        load_settings(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                      16'($urandom_range(1, 65535)), 6'($urandom), 6'($urandom),
                      6'($urandom), 6'($urandom));
        run_phase(130);

        repeat (40) @(posedge clk);
        $display("Summary: %0d frames under %0d register loads, %0d results compared.",
                 frames_sent, settings_loaded, checked_count);
        $display("Covered skipped frames, time wrap, saturated fades, stand-up and long stalls.");
        if (fail_count == 0 && expected_left == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
